>>> rtl/core/rtep_pkg.sv
package rtep_pkg;

   localparam int unsigned MAX_WIDTH  = 4096;
   localparam int unsigned WIDTH_W    = 13;
   localparam int unsigned HEIGHT_W   = 16;
   localparam int unsigned THRESH_W   = 9;
   localparam int unsigned FEED_W     = 8;
   localparam int unsigned COL_W      = 12;
   localparam int unsigned XB_W       = 10;
   localparam int unsigned LUM_W      = 19;
   localparam int unsigned SEQ_W      = 5;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd384;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd1;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 9'd128;
   localparam logic [FEED_W-1:0]   FEED_RESET   = 8'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FEED   = 2'd3;

   localparam logic [LUM_W-1:0] LUM_RED    = 19'd299;
   localparam logic [LUM_W-1:0] LUM_GREEN  = 19'd587;
   localparam logic [LUM_W-1:0] LUM_BLUE   = 19'd114;
   localparam logic [LUM_W-1:0] THR_SCALE  = 19'd1000;

   localparam logic [7:0] BYTE_ESC  = 8'h1B;
   localparam logic [7:0] BYTE_AT   = 8'h40;
   localparam logic [7:0] BYTE_GS   = 8'h1D;
   localparam logic [7:0] BYTE_LC_V = 8'h76;
   localparam logic [7:0] BYTE_ZERO = 8'h30;
   localparam logic [7:0] BYTE_MODE = 8'h00;
   localparam logic [7:0] BYTE_LC_D = 8'h64;
   localparam logic [7:0] BYTE_UC_V = 8'h56;
   localparam logic [7:0] BYTE_CUT  = 8'h01;
   localparam logic [7:0] BIT_MSB   = 8'h80;

   // position within the byte sequence of one pixel's results
   localparam logic [SEQ_W-1:0] SEQ_HDR_ESC  = 5'd0;
   localparam logic [SEQ_W-1:0] SEQ_HDR_AT   = 5'd1;
   localparam logic [SEQ_W-1:0] SEQ_HDR_GS   = 5'd2;
   localparam logic [SEQ_W-1:0] SEQ_HDR_V    = 5'd3;
   localparam logic [SEQ_W-1:0] SEQ_HDR_ZERO = 5'd4;
   localparam logic [SEQ_W-1:0] SEQ_HDR_MODE = 5'd5;
   localparam logic [SEQ_W-1:0] SEQ_HDR_XL   = 5'd6;
   localparam logic [SEQ_W-1:0] SEQ_HDR_XH   = 5'd7;
   localparam logic [SEQ_W-1:0] SEQ_HDR_YL   = 5'd8;
   localparam logic [SEQ_W-1:0] SEQ_HDR_YH   = 5'd9;
   localparam logic [SEQ_W-1:0] SEQ_DATA     = 5'd10;
   localparam logic [SEQ_W-1:0] SEQ_TRL_ESC  = 5'd11;
   localparam logic [SEQ_W-1:0] SEQ_TRL_D    = 5'd12;
   localparam logic [SEQ_W-1:0] SEQ_TRL_FEED = 5'd13;
   localparam logic [SEQ_W-1:0] SEQ_TRL_GS   = 5'd14;
   localparam logic [SEQ_W-1:0] SEQ_TRL_V    = 5'd15;
   localparam logic [SEQ_W-1:0] SEQ_TRL_CUT  = 5'd16;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_DATA    = 2'd1,
      KIND_TRAILER = 2'd2
   } byte_kind_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [7:0]    out_byte;
      byte_kind_type byte_kind;
      logic          run_last;
      logic          frame_end;
   } rsp_type;

endpackage

>>> rtl/core/rgb_threshold_escpos_raster_packer.sv
// A pixel is registered in the pixel stage; one that completes a byte then loads the
// job stage, whose registers drive rsp_valid and the first result byte.
// Throughput: 1 pixel per cycle while each pixel yields at most one byte and rsp_ready
// is high; a pixel that yields n bytes (header, data, trailer, up to 17) holds the
// output port for its n bytes, one byte per cycle while rsp_ready is high.
// Reset: synchronous; clears counters and stages, loads register reset values.
module rgb_threshold_escpos_raster_packer
   import rtep_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [THRESH_W-1:0] thresh_ff;
   logic [FEED_W-1:0]   feed_ff;

   logic                pix_valid_ff;
   req_type             pix_ff;

   logic [COL_W-1:0]    col_ff, col_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   logic [7:0]          pack_ff, pack_in;
   logic [2:0]          bit_ff, bit_in;
   logic                hdr_sent_ff, hdr_sent_in;

   logic                job_valid_ff;
   logic                job_trl_ff;
   logic [7:0]          job_byte_ff;
   logic [SEQ_W-1:0]    seq_ff;

   logic [WIDTH_W-1:0]  eff_w;
   logic [HEIGHT_W-1:0] eff_h;
   logic [WIDTH_W-1:0]  xb_sum;
   logic [XB_W-1:0]     xb;
   logic [LUM_W-1:0]    lum;
   logic [LUM_W-1:0]    thr_scaled;
   logic                black;
   logic                row_end;
   logic                byte_done;
   logic                img_end;
   logic [7:0]          bits_set;
   logic                seq_last;
   logic                job_free;
   logic                adv;
   logic [7:0]          out_byte;
   byte_kind_type       kind;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         thresh_ff <= THRESH_RESET;
         feed_ff   <= FEED_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_data[WIDTH_W-1:0];
            CSR_HEIGHT: height_ff <= csr_data[HEIGHT_W-1:0];
            CSR_THRESH: thresh_ff <= csr_data[THRESH_W-1:0];
            CSR_FEED:   feed_ff   <= csr_data[FEED_W-1:0];
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         eff_w = WIDTH_W'(1);
      end else if (width_ff > WIDTH_W'(MAX_WIDTH)) begin
         eff_w = WIDTH_W'(MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
   end

   assign eff_h  = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;
   assign xb_sum = eff_w + WIDTH_W'(7);
   assign xb     = xb_sum[WIDTH_W-1:3];

   assign lum = LUM_RED * LUM_W'(pix_ff.red) + LUM_GREEN * LUM_W'(pix_ff.green)
              + LUM_BLUE * LUM_W'(pix_ff.blue);
   assign thr_scaled = LUM_W'(thresh_ff) * THR_SCALE;
   assign black      = lum < thr_scaled;

   assign row_end   = ({1'b0, col_ff} + WIDTH_W'(1)) >= eff_w;
   assign byte_done = row_end || (bit_ff == 3'd7);
   assign img_end   = row_end && (({1'b0, row_ff} + 17'd1) >= {1'b0, eff_h});
   assign bits_set  = pack_ff | (black ? (BIT_MSB >> bit_ff) : 8'h00);

   assign seq_last = job_trl_ff ? (seq_ff == SEQ_TRL_CUT) : (seq_ff == SEQ_DATA);
   assign job_free = !job_valid_ff || (rsp_ready && seq_last);
   assign adv      = pix_valid_ff && (!byte_done || job_free);
   assign req_ready = !pix_valid_ff || adv;

   always_comb begin
      col_in      = row_end ? '0 : col_ff + COL_W'(1);
      row_in      = img_end ? '0 : (row_end ? row_ff + HEIGHT_W'(1) : row_ff);
      pack_in     = byte_done ? 8'h00 : bits_set;
      bit_in      = byte_done ? 3'd0 : bit_ff + 3'd1;
      hdr_sent_in = img_end ? 1'b0 : (byte_done ? 1'b1 : hdr_sent_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
      end else if (req_ready) begin
         pix_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         pix_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         pack_ff     <= '0;
         bit_ff      <= '0;
         hdr_sent_ff <= 1'b0;
      end else if (adv) begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         pack_ff     <= pack_in;
         bit_ff      <= bit_in;
         hdr_sent_ff <= hdr_sent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         seq_ff       <= '0;
      end else if (adv && byte_done) begin
         job_valid_ff <= 1'b1;
         seq_ff       <= hdr_sent_ff ? SEQ_DATA : SEQ_HDR_ESC;
      end else if (job_valid_ff && rsp_ready) begin
         if (seq_last) begin
            job_valid_ff <= 1'b0;
         end else begin
            seq_ff <= seq_ff + SEQ_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && byte_done) begin
         job_trl_ff  <= img_end;
         job_byte_ff <= bits_set;
      end
   end

   always_comb begin
      unique case (seq_ff)
         SEQ_HDR_ESC:  out_byte = BYTE_ESC;
         SEQ_HDR_AT:   out_byte = BYTE_AT;
         SEQ_HDR_GS:   out_byte = BYTE_GS;
         SEQ_HDR_V:    out_byte = BYTE_LC_V;
         SEQ_HDR_ZERO: out_byte = BYTE_ZERO;
         SEQ_HDR_MODE: out_byte = BYTE_MODE;
         SEQ_HDR_XL:   out_byte = xb[7:0];
         SEQ_HDR_XH:   out_byte = 8'(xb[XB_W-1:8]);
         SEQ_HDR_YL:   out_byte = eff_h[7:0];
         SEQ_HDR_YH:   out_byte = eff_h[15:8];
         SEQ_DATA:     out_byte = job_byte_ff;
         SEQ_TRL_ESC:  out_byte = BYTE_ESC;
         SEQ_TRL_D:    out_byte = BYTE_LC_D;
         SEQ_TRL_FEED: out_byte = feed_ff;
         SEQ_TRL_GS:   out_byte = BYTE_GS;
         SEQ_TRL_V:    out_byte = BYTE_UC_V;
         SEQ_TRL_CUT:  out_byte = BYTE_CUT;
         default:      out_byte = 8'h00;
      endcase
   end

   always_comb begin
      if (seq_ff < SEQ_DATA) begin
         kind = KIND_HEADER;
      end else if (seq_ff == SEQ_DATA) begin
         kind = KIND_DATA;
      end else begin
         kind = KIND_TRAILER;
      end
   end

   assign rsp_valid          = job_valid_ff;
   assign rsp_data.out_byte  = out_byte;
   assign rsp_data.byte_kind = kind;
   assign rsp_data.run_last  = seq_last;
   assign rsp_data.frame_end = seq_last && job_trl_ff;

endmodule

>>> tb/tb_rgb_threshold_escpos_raster_packer.sv
`timescale 1ns / 100ps

module tb_rgb_threshold_escpos_raster_packer
   import rtep_pkg::*;
;

   localparam int unsigned IDLE_LIMIT    = 5000;
   localparam int unsigned DRAIN_CYCLES  = 8;
   localparam int unsigned RANDOM_PIXELS = 140;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned MAX_PRINTED   = 30;

   typedef enum {SEND_STEADY, SEND_BURSTY} send_mode_type;
   typedef enum {READY_ALWAYS, READY_RANDOM, READY_PERIODIC} ready_mode_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int unsigned cfg_width;
   int unsigned cfg_height;
   int unsigned cfg_thresh;
   int unsigned cfg_feed;
   int unsigned pix_col;
   int unsigned pix_row;
   int unsigned bit_pos;
   logic [7:0]  pack_byte;
   bit          header_done;
   rsp_type     pending_bytes[$];

   send_mode_type  gap_mode   = SEND_STEADY;
   ready_mode_type ready_mode = READY_ALWAYS;
   int unsigned    burst_left = 0;
   int unsigned    hold_left  = 0;
   int unsigned    idle_cycles = 0;
   int unsigned    error_count = 0;
   int unsigned    pixels_sent = 0;
   int unsigned    bytes_checked = 0;
   int unsigned    frames_seen = 0;
   int unsigned    csr_writes = 0;

   rgb_threshold_escpos_raster_packer DUT (.*);

   always #5 clock = ~clock;

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("ERROR %0t: %s", $time, msg);
      end
   endtask

   function automatic rsp_type cmd_byte(input logic [7:0] value, input byte_kind_type kind);
      cmd_byte = '{out_byte: value, byte_kind: kind, run_last: 1'b0, frame_end: 1'b0};
   endfunction

   task automatic reset_printer_state();
      cfg_width   = WIDTH_RESET;
      cfg_height  = HEIGHT_RESET;
      cfg_thresh  = THRESH_RESET;
      cfg_feed    = FEED_RESET;
      pix_col     = 0;
      pix_row     = 0;
      bit_pos     = 0;
      pack_byte   = 8'h00;
      header_done = 1'b0;
   endtask

   task automatic predict_pixel(input req_type px);
      rsp_type     seq [17];
      logic [7:0]  hdr [10];
      logic [7:0]  trl [6];
      int unsigned luma;
      int unsigned w;
      int unsigned h;
      int unsigned xb;
      int unsigned n;
      bit          row_end;
      n = 0;
      luma = LUM_RED * px.red + LUM_GREEN * px.green + LUM_BLUE * px.blue;
      w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
      h = (cfg_height == 0) ? 1 : cfg_height;
      if (luma < cfg_thresh * THR_SCALE) begin
         pack_byte = pack_byte | (BIT_MSB >> bit_pos);
      end
      row_end = (pix_col + 1 >= w);
      if (row_end || bit_pos >= 7) begin
         if (!header_done) begin
            xb = (w + 7) / 8;
            hdr = '{BYTE_ESC, BYTE_AT, BYTE_GS, BYTE_LC_V, BYTE_ZERO, BYTE_MODE,
                    8'(xb), 8'(xb >> 8), 8'(h), 8'(h >> 8)};
            foreach (hdr[i]) begin
               seq[n] = cmd_byte(hdr[i], KIND_HEADER);
               n++;
            end
            header_done = 1'b1;
         end
         seq[n] = cmd_byte(pack_byte, KIND_DATA);
         n++;
         pack_byte = 8'h00;
         bit_pos = 0;
      end else begin
         bit_pos++;
      end
      if (row_end) begin
         pix_col = 0;
         if (pix_row + 1 >= h) begin
            trl = '{BYTE_ESC, BYTE_LC_D, 8'(cfg_feed), BYTE_GS, BYTE_UC_V, BYTE_CUT};
            foreach (trl[i]) begin
               seq[n] = cmd_byte(trl[i], KIND_TRAILER);
               n++;
            end
            seq[n-1].frame_end = 1'b1;
            pix_row = 0;
            header_done = 1'b0;
         end else begin
            pix_row++;
         end
      end else begin
         pix_col++;
      end
      if (n > 0) begin
         seq[n-1].run_last = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         pending_bytes.push_back(seq[i]);
      end
   endtask

   function automatic req_type random_pixel();
      req_type     px;
      int unsigned v;
      px = 24'($urandom);
      case ($urandom_range(0, 3))
         1: begin
            v = (cfg_thresh > 255) ? 255 : cfg_thresh;
            if (v > 0 && $urandom_range(0, 1) == 1) begin
               v--;
            end
            px.red   = 8'(v);
            px.green = 8'(v);
            px.blue  = 8'(v);
         end
         2: begin
            px.red   = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            px.green = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            px.blue  = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
         end
         default: begin
         end
      endcase
      return px;
   endfunction

   task automatic send_pixel(input req_type px);
      int unsigned gap;
      if (gap_mode == SEND_BURSTY && burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (!req_ready);
      predict_pixel(px);
      pixels_sent++;
   endtask

   task automatic send_image();
      do send_pixel(random_pixel()); while (pix_col != 0 || pix_row != 0);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_bytes.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_WIDTH:  cfg_width  = value[WIDTH_W-1:0];
         CSR_HEIGHT: cfg_height = value[HEIGHT_W-1:0];
         CSR_THRESH: cfg_thresh = value[THRESH_W-1:0];
         CSR_FEED:   cfg_feed   = value[FEED_W-1:0];
         default: begin
         end
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int unsigned w, input int unsigned h,
                            input int unsigned t, input int unsigned f);
      write_csr(CSR_WIDTH,  {3'($urandom), 13'(w)});
      write_csr(CSR_HEIGHT, 16'(h));
      write_csr(CSR_THRESH, {7'($urandom), 9'(t)});
      write_csr(CSR_FEED,   {8'($urandom), 8'(f)});
   endtask

   task automatic test_reset_defaults();
      req_type pixels [8];
      gap_mode   = SEND_STEADY;
      ready_mode = READY_ALWAYS;
      pixels = '{24'h7F7F7F, 24'h808080, 24'h000000, 24'hFFFFFF,
                 24'h800000, 24'h008000, 24'h000080, 24'h7F8081};
      foreach (pixels[i]) begin
         send_pixel(pixels[i]);
      end
      wait_idle();
      // shrink the row under the current column to close the image
      write_csr(CSR_WIDTH, 16'd9);
      send_pixel(24'h000000);
      wait_idle();
   endtask

   task automatic test_pixel_extremes();
      req_type pixels [8];
      ready_mode = READY_RANDOM;
      configure(4, 2, 128, 0);
      pixels = '{24'h000000, 24'hFFFFFF, 24'h7F7F7F, 24'h808080,
                 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h010101};
      for (int i = 0; i < 4; i++) begin
         send_pixel(pixels[i]);
      end
      wait_idle();
      write_csr(CSR_HEIGHT, 16'd1);
      for (int i = 4; i < 8; i++) begin
         send_pixel(pixels[i]);
      end
      wait_idle();
   endtask

   task automatic test_threshold_and_size_extremes();
      ready_mode = READY_PERIODIC;
      configure(0, 0, 0, 255);
      write_csr(CSR_THRESH, 16'hFFFF);
      send_pixel(24'hFFFFFF);
      wait_idle();
      write_csr(CSR_THRESH, 16'd0);
      send_pixel(24'h000000);
      wait_idle();
      write_csr(CSR_THRESH, 16'd256);
      send_pixel(24'hFFFFFF);
      wait_idle();
   endtask

   task automatic test_large_frame_header();
      gap_mode   = SEND_BURSTY;
      ready_mode = READY_RANDOM;
      write_csr(CSR_WIDTH, 16'hFFFF);
      write_csr(CSR_HEIGHT, 16'hFFFF);
      write_csr(CSR_THRESH, 16'd300);
      write_csr(CSR_FEED, 16'h0000);
      repeat (8) send_pixel(random_pixel());
      wait_idle();
      write_csr(CSR_WIDTH, 16'd4);
      write_csr(CSR_HEIGHT, 16'd1);
      send_pixel(random_pixel());
      wait_idle();
   endtask

   task automatic test_output_backpressure();
      configure(3, 2, $urandom_range(64, 192), $urandom_range(0, 255));
      gap_mode   = SEND_STEADY;
      ready_mode = READY_ALWAYS;
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      repeat (4) send_image();
      ready_mode = READY_RANDOM;
      repeat (2) send_image();
      wait_idle();
   endtask

   task automatic test_random_images();
      int unsigned start;
      int unsigned w;
      int unsigned h;
      int unsigned t;
      start = pixels_sent;
      while (pixels_sent - start < RANDOM_PIXELS) begin
         case ($urandom_range(0, 9))
            0: begin
               w = $urandom_range(64, 128);
               h = 1;
            end
            1, 2: begin
               w = $urandom_range(21, 48);
               h = $urandom_range(1, 2);
            end
            default: begin
               w = $urandom_range(0, 20);
               h = $urandom_range(0, 3);
            end
         endcase
         t = ($urandom_range(0, 7) == 0) ? $urandom_range(257, 511) : $urandom_range(0, 256);
         configure(w, h, t, $urandom_range(0, 255));
         gap_mode   = send_mode_type'($urandom_range(0, 1));
         ready_mode = ready_mode_type'($urandom_range(0, 2));
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 12)) send_pixel(random_pixel());
            wait_idle();
            configure($urandom_range(1, 12), $urandom_range(1, 3), cfg_thresh, cfg_feed);
         end
         repeat ($urandom_range(1, 2)) send_image();
         wait_idle();
      end
   endtask

   initial begin
      int unsigned phase;
      rsp_ready = 1'b0;
      phase = 0;
      forever begin
         @(negedge clock);
         phase++;
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            case (ready_mode)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
               default:      rsp_ready <= ((phase % 7) >= 3);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         bytes_checked++;
         if (rsp_data.frame_end) begin
            frames_seen++;
         end
         if (pending_bytes.size() == 0) begin
            report_error($sformatf("unexpected byte %h kind %0d",
                                   rsp_data.out_byte, rsp_data.byte_kind));
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               report_error($sformatf("byte %0d: out_byte %h, want %h",
                                      bytes_checked, rsp_data.out_byte, want.out_byte));
            end
            if (rsp_data.byte_kind !== want.byte_kind) begin
               report_error($sformatf("byte %0d: byte_kind %0d, want %0d",
                                      bytes_checked, rsp_data.byte_kind, want.byte_kind));
            end
            if (rsp_data.run_last !== want.run_last) begin
               report_error($sformatf("byte %0d: run_last %b, want %b",
                                      bytes_checked, rsp_data.run_last, want.run_last));
            end
            if (rsp_data.frame_end !== want.frame_end) begin
               report_error($sformatf("byte %0d: frame_end %b, want %b",
                                      bytes_checked, rsp_data.frame_end, want.frame_end));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles, %0d bytes still due",
                  idle_cycles, pending_bytes.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_WIDTH;
      csr_data  = '0;
      reset_printer_state();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_pixel_extremes();
      test_threshold_and_size_extremes();
      test_large_frame_header();
      test_output_backpressure();
      test_random_images();

      wait_idle();
      repeat (4 * DRAIN_CYCLES) @(posedge clock);
      $display("Run covered %0d pixels, %0d command bytes, %0d images, %0d register writes.",
               pixels_sent, bytes_checked, frames_seen, csr_writes);
      $display("Scope: reset values, threshold edges, clamped sizes, output hold, random frames.");
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/rtep_pkg.sv
rtl/core/rgb_threshold_escpos_raster_packer.sv
tb/tb_rgb_threshold_escpos_raster_packer.sv
